// ===== design/cisr_pkg.sv =====
// ---------------------------------------------------------------------------
// cisr_pkg: shared types for the configuration item select/read port
// Beat kinds on the input stream and the state encoding of the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package cisr_pkg;

	typedef enum logic [2:0] {
		MODE_SELECT = 3'd0,
		MODE_READ   = 3'd1,
		MODE_WRITE  = 3'd2,
		MODE_LOAD   = 3'd3,
		MODE_DEFINE = 3'd4
	} mode_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_META  = 5'b00100,
		ST_DATA  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic        entry_present;
		logic [8:0]  entry_size;
		logic [7:0]  byte_value;
		logic [7:0]  byte_offset;
		logic [15:0] item_key;
	} item_t;

	localparam int KEY_INDEX_W = 14;
	localparam int KEY_BANK_BIT = 15;

endpackage

`default_nettype wire

// ===== design/cisr_ram.sv =====
// ---------------------------------------------------------------------------
// cisr_ram: single-port synchronous RAM
// One access per cycle, write or read at the same address, read data
// registered.
// ---------------------------------------------------------------------------
`default_nettype none

module cisr_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wdata,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// ===== design/config_item_select_read_port.sv =====
// ---------------------------------------------------------------------------
// config_item_select_read_port: configuration item store with select and
// byte data port
// Two banks of entries with a length table and a byte memory, driven by a
// small sequencer.
// ---------------------------------------------------------------------------
// Items arrive as beats on the s_ channel; the kind of access travels in
// s_tuser and the operands in s_tdata. Every beat yields exactly one result
// beat on the m_ channel, with the data byte in m_tdata and the select status
// in m_tuser.
// The length table is read at the edge that accepts a beat, the byte memory
// is read or written in the next cycle, and the result is formed in the one
// after and goes to the output register. Both memories are single-ported
// with registered reads, and the sequencer handles one item at a time, so a
// new beat is taken only once the previous item has left the sequencer.
// The output register holds a finished result while the next beat is already
// accepted; if the receiver still stalls when that beat is done, the
// sequencer waits with its result until the output register frees up.
// After reset the length table is swept to zero, one entry per cycle, over
// all 2*ENTRY_COUNT entries, and s_tready stays low during that sweep. Reset
// selects key 0 with the read offset at zero.
// ---------------------------------------------------------------------------
`default_nettype none

module config_item_select_read_port
	import cisr_pkg::*;
#(
	parameter int ENTRY_COUNT = 64,
	parameter int ENTRY_BYTES = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [15:0] item_key, [23:16] byte_offset, [31:24] byte_value,
	// [40:32] entry_size, [41] entry_present, [47:42] zero
	input  wire logic [47:0] s_tdata,
	// [2:0] mode
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] read_byte
	output logic [7:0]       m_tdata,
	// [0] select_valid
	output logic             m_tuser
);

	localparam int SLOTS   = 2 * ENTRY_COUNT;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int LEN_W   = $clog2(ENTRY_BYTES + 1);
	localparam int META_W  = LEN_W + 1;
	localparam int BYTE_AW = $clog2(64'(SLOTS) * 64'(ENTRY_BYTES));

	typedef struct packed {
		logic             ok;
		logic [SLOT_W-1:0] slot;
	} slot_ref_t;

	function automatic slot_ref_t slot_of(input logic [15:0] key);
		slot_ref_t         r;
		logic [14:0]       idx;
		logic [14:0]       sum;
		idx    = {1'b0, key[KEY_INDEX_W-1:0]};
		sum    = idx + (key[KEY_BANK_BIT] ? 15'(ENTRY_COUNT) : 15'd0);
		r.ok   = idx < 15'(ENTRY_COUNT);
		r.slot = SLOT_W'(sum);
		return r;
	endfunction

	state_t            state_q;
	logic [SLOT_W-1:0] clr_q;
	logic [2:0]        mode_q;
	item_t             item_q;
	logic              key_ok_q;
	logic [SLOT_W-1:0] sel_slot_q;
	logic [LEN_W-1:0]  offset_q;
	logic              hit_s2;
	logic              sv_s2;
	logic [7:0]        res_byte_q;
	logic              res_sv_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_sv_q;

	slot_ref_t         item_ref;
	logic              meta_we;
	logic [SLOT_W-1:0] meta_addr;
	logic [META_W-1:0] meta_wdata;
	logic [META_W-1:0] meta_rdata;
	logic              byte_we;
	logic [BYTE_AW-1:0] byte_addr;
	logic [7:0]        byte_rdata;
	logic              read_hit;
	logic [LEN_W-1:0]  def_len;
	logic              out_free;
	logic              out_load;
	logic [7:0]        fin_byte;
	logic              accept;

	assign item_ref = slot_of(item_q.item_key);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = ((state_q == ST_DATA) || (state_q == ST_DONE)) && out_free;
	assign s_tready = (state_q == ST_IDLE);

	assign read_hit = key_ok_q && meta_rdata[LEN_W] && (offset_q < meta_rdata[LEN_W-1:0]);

	always_comb begin
		if (32'(item_q.entry_size) > 32'(ENTRY_BYTES)) begin
			def_len = LEN_W'(ENTRY_BYTES);
		end else begin
			def_len = LEN_W'(item_q.entry_size);
		end
	end

	always_comb begin
		meta_we    = 1'b0;
		meta_addr  = sel_slot_q;
		meta_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				meta_we   = 1'b1;
				meta_addr = clr_q;
			end
			ST_META: begin
				if (mode_q == MODE_DEFINE && item_ref.ok) begin
					meta_we    = 1'b1;
					meta_addr  = item_ref.slot;
					meta_wdata = item_q.entry_present ? {1'b1, def_len} : '0;
				end
			end
			default: begin
				meta_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		byte_we = 1'b0;
		if (mode_q == MODE_LOAD) begin
			byte_we   = (state_q == ST_META) && item_ref.ok &&
				(32'(item_q.byte_offset) < 32'(ENTRY_BYTES));
			byte_addr = BYTE_AW'(64'(item_ref.slot) * 64'(ENTRY_BYTES) +
				64'(item_q.byte_offset));
		end else begin
			byte_addr = BYTE_AW'(64'(sel_slot_q) * 64'(ENTRY_BYTES) + 64'(offset_q));
		end
	end

	cisr_ram #(
		.ADDR_W (SLOT_W),
		.DATA_W (META_W)
	) u_meta_ram (
		.clk   (clk),
		.we    (meta_we),
		.addr  (meta_addr),
		.wdata (meta_wdata),
		.rdata (meta_rdata)
	);

	cisr_ram #(
		.ADDR_W (BYTE_AW),
		.DATA_W (8)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.addr  (byte_addr),
		.wdata (item_q.byte_value),
		.rdata (byte_rdata)
	);

	assign fin_byte = hit_s2 ? byte_rdata : 8'd0;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			item_q <= s_tdata[41:0];
		end
		if (state_q == ST_META) begin
			hit_s2 <= (mode_q == MODE_READ) && read_hit;
			sv_s2  <= (mode_q == MODE_SELECT) && item_ref.ok;
		end
		if (state_q == ST_DATA) begin
			res_byte_q <= fin_byte;
			res_sv_q   <= sv_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			key_ok_q    <= 1'b1;
			sel_slot_q  <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_sv_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					if (mode_q == MODE_SELECT) begin
						offset_q <= '0;
						key_ok_q <= item_ref.ok;
						if (item_ref.ok) begin
							sel_slot_q <= item_ref.slot;
						end
					end else if (mode_q == MODE_READ && read_hit) begin
						offset_q <= offset_q + 1'b1;
					end
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					if (out_free) begin
						out_byte_q  <= fin_byte;
						out_sv_q    <= sv_s2;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_byte_q  <= res_byte_q;
						out_sv_q    <= res_sv_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_sv_q;

	a_accept_to_meta: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_META)
		else $error("accepted beat did not enter the table read cycle");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !s_tready)
		else $error("beat taken during the length table sweep");

	a_done_means_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> out_valid_q)
		else $error("result held back although the output register is free");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(offset_q) <= 32'(ENTRY_BYTES))
		else $error("read offset ran past the entry capacity");

endmodule

`default_nettype wire
